// ===== rtl/climate_hysteresis_controller_assert.svh =====
// ----------------------------------------------------------------------------
// climate hysteresis controller assertion macros
// clocked on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef CLIMATE_HYSTERESIS_CONTROLLER_ASSERT_SVH
`define CLIMATE_HYSTERESIS_CONTROLLER_ASSERT_SVH

// property holds in the same cycle as its antecedent
`define CHC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// property holds in the cycle after its antecedent
`define CHC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/chc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chc_pkg
// types and constants shared by the climate hysteresis controller
// ----------------------------------------------------------------------------
package chc_pkg;

  localparam int unsigned TEMP_W     = 12;
  localparam int unsigned HUMID_W    = 10;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned CFG_IDX_W  = 3;
  // compare width, holds limit +/- band without overflow
  localparam int unsigned CMP_W      = 14;

  localparam logic signed [CMP_W-1:0] TEMP_BAND  = 14'sd20;
  localparam logic signed [CMP_W-1:0] HUMID_BAND = 14'sd50;

  localparam logic [TEMP_W-1:0]  HEATER_TEMP_RST  = 12'd200;
  localparam logic [TEMP_W-1:0]  FAN_TEMP_RST     = 12'd300;
  localparam logic [HUMID_W-1:0] FAN_HUMID_RST    = 10'd800;
  localparam logic [TEMP_W-1:0]  VENT_TEMP_RST    = 12'd320;
  localparam logic [HUMID_W-1:0] VENT_HUMID_RST   = 10'd850;
  localparam logic [HUMID_W-1:0] HEATER_HUMID_RST = 10'd900;
  localparam logic               DEHUMIDIFY_RST   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEATER_TEMP  = 3'd0,
    CFG_FAN_TEMP     = 3'd1,
    CFG_FAN_HUMID    = 3'd2,
    CFG_VENT_TEMP    = 3'd3,
    CFG_VENT_HUMID   = 3'd4,
    CFG_HEATER_HUMID = 3'd5,
    CFG_DEHUMIDIFY   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [TEMP_W-1:0]  heater_temp_limit;
    logic [TEMP_W-1:0]  fan_temp_limit;
    logic [HUMID_W-1:0] fan_humid_limit;
    logic [TEMP_W-1:0]  vent_temp_limit;
    logic [HUMID_W-1:0] vent_humid_limit;
    logic [HUMID_W-1:0] heater_humid_limit;
    logic               dehumidify_enable;
  } cfg_t;

  // one bit per actuator
  typedef struct packed {
    logic heater;
    logic vent;
    logic fan;
  } act_t;

  typedef struct packed {
    logic [TEMP_W-1:0]  temperature;
    logic [HUMID_W-1:0] humidity;
    act_t               overrides;
  } sample_t;

  function automatic logic signed [CMP_W-1:0] temp_ext(input logic [TEMP_W-1:0] v);
    return $signed({{(CMP_W-TEMP_W){v[TEMP_W-1]}}, v});
  endfunction

  function automatic logic signed [CMP_W-1:0] humid_ext(input logic [HUMID_W-1:0] v);
    return $signed({{(CMP_W-HUMID_W){1'b0}}, v});
  endfunction

endpackage

// ===== rtl/climate_hysteresis_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// climate_hysteresis_controller
// fan, vent and heater hysteresis controller, one sample per transfer
// ----------------------------------------------------------------------------
// path: a sample is registered in s1, its result in the actuator state registers
// throughput: one sample per cycle unless out_stall_i holds the result register,
//   set by the loop from the actuator state registers through the decision logic
// reset: actuators off, result register empty, limits at their defaults
// ----------------------------------------------------------------------------
`include "climate_hysteresis_controller_assert.svh"

module climate_hysteresis_controller
  import chc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [TEMP_W-1:0]     temperature_i,
  input  logic [HUMID_W-1:0]    humidity_i,
  input  logic                  fan_override_i,
  input  logic                  vent_override_i,
  input  logic                  heater_override_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  fan_on_o,
  output logic                  vent_open_o,
  output logic                  heater_on_o,
  output logic [2:0]            changed_o
);

  cfg_t    cfg;
  sample_t s1_sample_q;
  logic    s1_valid_q;
  logic    out_valid_q;
  act_t    state_q;
  act_t    state_d;
  logic [2:0] changed_q;
  logic    adv;
  logic    s1_take;
  logic    in_take;

  chc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  chc_decide u_decide (
    .cfg_i    (cfg),
    .sample_i (s1_sample_q),
    .state_i  (state_q),
    .state_o  (state_d)
  );

  // result register free or draining this cycle
  assign adv        = !out_valid_q || !out_stall_i;
  assign s1_take    = s1_valid_q && adv;
  assign in_stall_o = s1_valid_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_take) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_sample_q.temperature      <= temperature_i;
      s1_sample_q.humidity         <= humidity_i;
      s1_sample_q.overrides.fan    <= fan_override_i;
      s1_sample_q.overrides.vent   <= vent_override_i;
      s1_sample_q.overrides.heater <= heater_override_i;
    end
    if (s1_take) begin
      changed_q <= {state_q.heater ^ state_d.heater,
                    state_q.vent ^ state_d.vent,
                    state_q.fan ^ state_d.fan};
    end
  end

  // state registers double as the result fields
  assign out_valid_o = out_valid_q;
  assign fan_on_o    = state_q.fan;
  assign vent_open_o = state_q.vent;
  assign heater_on_o = state_q.heater;
  assign changed_o   = changed_q;

  `CHC_ASSERT_NOW(a_no_stall_when_empty, !out_valid_q, !in_stall_o, "stall with empty result register")
  `CHC_ASSERT_NEXT(a_fan_override_holds, s1_take && s1_sample_q.overrides.fan, !changed_o[0], "overridden fan changed")
  `CHC_ASSERT_NEXT(a_heater_change_flag, s1_take, changed_o[2] == (heater_on_o ^ $past(heater_on_o)), "heater change flag wrong")
  `CHC_ASSERT_NEXT(a_result_follows_sample, s1_take, out_valid_o, "result missing after sample")

endmodule

// ===== rtl/chc_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chc_cfg_regs
// limit and mode register file, written through a plain write port
// ----------------------------------------------------------------------------
module chc_cfg_regs
  import chc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.heater_temp_limit  <= HEATER_TEMP_RST;
      cfg_q.fan_temp_limit     <= FAN_TEMP_RST;
      cfg_q.fan_humid_limit    <= FAN_HUMID_RST;
      cfg_q.vent_temp_limit    <= VENT_TEMP_RST;
      cfg_q.vent_humid_limit   <= VENT_HUMID_RST;
      cfg_q.heater_humid_limit <= HEATER_HUMID_RST;
      cfg_q.dehumidify_enable  <= DEHUMIDIFY_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_HEATER_TEMP:  cfg_q.heater_temp_limit  <= cfg_wdata_i[TEMP_W-1:0];
        CFG_FAN_TEMP:     cfg_q.fan_temp_limit     <= cfg_wdata_i[TEMP_W-1:0];
        CFG_FAN_HUMID:    cfg_q.fan_humid_limit    <= cfg_wdata_i[HUMID_W-1:0];
        CFG_VENT_TEMP:    cfg_q.vent_temp_limit    <= cfg_wdata_i[TEMP_W-1:0];
        CFG_VENT_HUMID:   cfg_q.vent_humid_limit   <= cfg_wdata_i[HUMID_W-1:0];
        CFG_HEATER_HUMID: cfg_q.heater_humid_limit <= cfg_wdata_i[HUMID_W-1:0];
        CFG_DEHUMIDIFY:   cfg_q.dehumidify_enable  <= cfg_wdata_i[0];
        default: begin
          // unused index, write dropped
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/chc_decide.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chc_decide
// hysteresis decisions for fan, vent and heater from one sample
// ----------------------------------------------------------------------------
module chc_decide
  import chc_pkg::*;
(
  input  cfg_t    cfg_i,
  input  sample_t sample_i,
  input  act_t    state_i,
  output act_t    state_o
);

  logic signed [CMP_W-1:0] t;
  logic signed [CMP_W-1:0] h;
  logic signed [CMP_W-1:0] heat_lim;
  logic signed [CMP_W-1:0] fan_t_lim;
  logic signed [CMP_W-1:0] fan_h_lim;
  logic signed [CMP_W-1:0] vent_t_lim;
  logic signed [CMP_W-1:0] vent_h_lim;
  logic signed [CMP_W-1:0] dry_h_lim;
  logic                    heat;
  logic                    fan_req;
  logic                    vent_req;
  logic                    dry_req;
  logic                    fan_nxt;
  logic                    vent_nxt;

  always_comb begin
    t          = temp_ext(sample_i.temperature);
    h          = humid_ext(sample_i.humidity);
    heat_lim   = temp_ext(cfg_i.heater_temp_limit);
    fan_t_lim  = temp_ext(cfg_i.fan_temp_limit);
    fan_h_lim  = humid_ext(cfg_i.fan_humid_limit);
    vent_t_lim = temp_ext(cfg_i.vent_temp_limit);
    vent_h_lim = humid_ext(cfg_i.vent_humid_limit);
    dry_h_lim  = humid_ext(cfg_i.heater_humid_limit);

    heat = (t < heat_lim) || (state_i.heater && (t < heat_lim + TEMP_BAND));

    fan_req = (t > fan_t_lim) || (h > fan_h_lim) ||
              (state_i.fan && ((t > fan_t_lim - TEMP_BAND) ||
                               (h > fan_h_lim - HUMID_BAND)));
    vent_req = (t > vent_t_lim) || (h > vent_h_lim) ||
               (state_i.vent && ((t > vent_t_lim - TEMP_BAND) ||
                                 (h > vent_h_lim - HUMID_BAND)));

    // heating forces fan and vent off unless they are overridden
    fan_nxt  = sample_i.overrides.fan  ? state_i.fan  : (!heat && fan_req);
    vent_nxt = sample_i.overrides.vent ? state_i.vent : (!heat && vent_req);

    // drying looks at the updated fan and vent, the old heater bit
    dry_req = cfg_i.dehumidify_enable && !fan_nxt && !vent_nxt &&
              ((h > dry_h_lim) ||
               (state_i.heater && (h > dry_h_lim - HUMID_BAND)));

    state_o.fan    = fan_nxt;
    state_o.vent   = vent_nxt;
    state_o.heater = sample_i.overrides.heater ? state_i.heater : (heat || dry_req);
  end

endmodule
